### hdl/bqe_pkg.sv
// shared types, codes and constants of the billboard quad expander
package bqe_pkg;

	localparam int CORDIC_ITERS = 16;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861
	};

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_INDEX = 1'b1;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_GLOBAL = 2'd1;
	localparam logic [1:0] MODE_ITEM = 2'd2;

	localparam logic [2:0] REG_RIGHT_X = 3'd0;
	localparam logic [2:0] REG_RIGHT_Y = 3'd1;
	localparam logic [2:0] REG_UP_X = 3'd2;
	localparam logic [2:0] REG_UP_Y = 3'd3;
	localparam logic [2:0] REG_QUAD_SCALE = 3'd4;
	localparam logic [2:0] REG_TINT_RGB = 3'd5;
	localparam logic [2:0] REG_ROT_MODE = 3'd6;
	localparam logic [2:0] REG_GLOBAL_ANGLE = 3'd7;

	// triangle order 0,1,2, 2,3,0
	localparam logic [1:0] TRI_ORDER [6] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0};

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [15:0] item;
		logic [16:0] quo;
	} item_t;

	typedef struct packed {
		item_t pl;
		logic signed [17:0] c;
		logic signed [17:0] s;
	} rot_t;

	typedef struct packed {
		logic kind;
		logic [1:0] corner;
		logic u;
		logic v;
		logic last;
		logic [17:0] vnum;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic signed [17:0] c;
		logic signed [17:0] s;
	} rec_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic [15:0] scale;
		logic [23:0] tint;
	} cam_t;

endpackage

### hdl/bqe_cordic.sv
// pipelined cordic sin/cos, one iteration per stage, with item number reduction
module bqe_cordic #(
	parameter int MAX_ITEMS = 65536,
	parameter int AKEEP = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [AKEEP-1:0] angle,
	input logic rot,
	input bqe_pkg::item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output bqe_pkg::rot_t out_data
);
	import bqe_pkg::*;

	localparam int NST = CORDIC_ITERS + 2;
	localparam bit MOD_EN = (MAX_ITEMS < 65536);
	localparam longint unsigned RECIP =
		((64'd1 << 32) + longint'(MAX_ITEMS) - 64'd1) / longint'(MAX_ITEMS);
	localparam logic [32:0] RECIP_W = RECIP[32:0];
	localparam logic [16:0] MOD_W = MAX_ITEMS[16:0];

	logic [NST-1:0] vld_s;
	logic [NST:0] en;

	logic signed [33:0] x_s [0:CORDIC_ITERS];
	logic signed [33:0] y_s [0:CORDIC_ITERS];
	logic signed [33:0] z_s [0:CORDIC_ITERS];
	logic neg_s [0:CORDIC_ITERS];
	logic rot_s [0:CORDIC_ITERS];
	item_t pl_s [0:CORDIC_ITERS];
	rot_t res_s;

	logic [31:0] ph;
	logic signed [33:0] z0;
	logic signed [33:0] zf;
	logic negf;

	assign en[NST] = out_ready;
	for (genvar g = 0; g < NST; g++) begin : g_en
		assign en[g] = !vld_s[g] || en[g+1];
	end
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// fold the turn phase into a quarter turn either side of zero
	always_comb begin
		ph = {angle, {(32 - AKEEP){1'b0}}};
		z0 = 34'(signed'(ph));
		zf = z0;
		negf = 1'b0;
		if (z0 > 34'sd1073741824) begin
			zf = z0 - 34'sd2147483648;
			negf = 1'b1;
		end else if (z0 < -34'sd1073741824) begin
			zf = z0 + 34'sd2147483648;
			negf = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= zf;
			neg_s[0] <= negf;
			rot_s[0] <= rot;
			pl_s[0] <= in_data;
		end
	end

	for (genvar g = 1; g <= CORDIC_ITERS; g++) begin : g_it
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] at;
		item_t pl_n;

		assign dx = y_s[g-1] >>> (g - 1);
		assign dy = x_s[g-1] >>> (g - 1);
		assign at = $signed({2'b00, ATAN_TURN[g-1]});

		always_comb begin
			pl_n = pl_s[g-1];
			if (MOD_EN && g == 1) begin
				pl_n.quo = 17'((49'(pl_s[g-1].item) * 49'(RECIP_W)) >> 32);
			end
			if (MOD_EN && g == 2) begin
				pl_n.item = pl_s[g-1].item - 16'(34'(pl_s[g-1].quo) * 34'(MOD_W));
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				if (z_s[g-1] >= 0) begin
					x_s[g] <= x_s[g-1] - dx;
					y_s[g] <= y_s[g-1] + dy;
					z_s[g] <= z_s[g-1] - at;
				end else begin
					x_s[g] <= x_s[g-1] + dx;
					y_s[g] <= y_s[g-1] - dy;
					z_s[g] <= z_s[g-1] + at;
				end
				neg_s[g] <= neg_s[g-1];
				rot_s[g] <= rot_s[g-1];
				pl_s[g] <= pl_n;
			end
		end
	end

	logic signed [34:0] xr;
	logic signed [34:0] yr;
	logic signed [34:0] xq;
	logic signed [34:0] yq;

	always_comb begin
		xr = neg_s[CORDIC_ITERS] ? -35'(x_s[CORDIC_ITERS]) : 35'(x_s[CORDIC_ITERS]);
		yr = neg_s[CORDIC_ITERS] ? -35'(y_s[CORDIC_ITERS]) : 35'(y_s[CORDIC_ITERS]);
		xq = (xr + 35'sd16384) >>> 15;
		yq = (yr + 35'sd16384) >>> 15;
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			res_s.pl <= pl_s[CORDIC_ITERS];
			if (rot_s[CORDIC_ITERS]) begin
				res_s.c <= xq[17:0];
				res_s.s <= yq[17:0];
			end else begin
				res_s.c <= 18'sd32768;
				res_s.s <= '0;
			end
		end
	end

	assign out_valid = vld_s[NST-1];
	assign out_data = res_s;

endmodule

### hdl/bqe_seq.sv
// record sequencer: four vertex records then six index entries per item
module bqe_seq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input bqe_pkg::rot_t in_data,
	output logic out_valid,
	input logic out_ready,
	output bqe_pkg::rec_t out_data
);
	import bqe_pkg::*;

	logic held_q;
	logic [3:0] cnt_q;
	rot_t item_q;
	logic fire;
	logic done;
	logic [1:0] idx;
	logic [2:0] tri_sel;

	assign fire = held_q && out_ready;
	assign done = fire && (cnt_q == 4'd9);
	assign in_ready = !held_q || done;
	assign out_valid = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				held_q <= 1'b1;
				cnt_q <= '0;
			end else if (done) begin
				held_q <= 1'b0;
				cnt_q <= '0;
			end else if (fire) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
	end

	always_comb begin
		tri_sel = 3'(cnt_q - 4'd4);
		if (cnt_q < 4'd4) begin
			idx = cnt_q[1:0];
		end else begin
			idx = TRI_ORDER[tri_sel];
		end
		out_data.kind = (cnt_q < 4'd4) ? KIND_VERTEX : KIND_INDEX;
		out_data.corner = idx;
		out_data.u = idx[0] ^ idx[1];
		out_data.v = ~idx[1];
		out_data.last = (cnt_q == 4'd9);
		out_data.vnum = {item_q.pl.item, 2'b00} + 18'(idx);
		out_data.cx = item_q.pl.cx;
		out_data.cy = item_q.pl.cy;
		out_data.cz = item_q.pl.cz;
		out_data.c = item_q.c;
		out_data.s = item_q.s;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'd9)
		else $error("record count past the last index entry");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!held_q |-> cnt_q == 4'd0)
		else $error("record count moved while empty");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		held_q && !out_ready |=> held_q)
		else $error("held item dropped under a stall");

endmodule

### hdl/bqe_corner.sv
// corner datapath: offset, rotation, rounding and saturation, four stages
module bqe_corner (
	input logic clk,
	input logic arst_n,
	input bqe_pkg::cam_t cam,
	input logic in_valid,
	output logic in_ready,
	input bqe_pkg::rec_t in_data,
	output logic out_valid,
	input logic out_ready,
	output bqe_pkg::rec_t out_rec,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic [23:0] out_colour
);
	import bqe_pkg::*;

	logic v1_s, v2_s, v3_s, v4_s;
	logic en1, en2, en3, en4;
	rec_t r1_s, r2_s, r3_s, r4_s;
	rec_t r4_n;
	logic signed [34:0] px_s1, py_s1;
	logic signed [52:0] pc_s2, qs_s2, ps_s2, qc_s2;
	logic signed [31:0] rx_s3, ry_s3;
	logic signed [31:0] x_s4, y_s4;
	logic [23:0] col_s4;

	assign en4 = !v4_s || out_ready;
	assign en3 = !v3_s || en4;
	assign en2 = !v2_s || en3;
	assign en1 = !v1_s || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			v3_s <= 1'b0;
			v4_s <= 1'b0;
		end else begin
			if (en1) v1_s <= in_valid;
			if (en2) v2_s <= v1_s;
			if (en3) v3_s <= v2_s;
			if (en4) v4_s <= v3_s;
		end
	end

	// corner signs: up negative on the lower pair, right negative on the left pair
	logic up_neg, rt_neg;
	logic signed [17:0] ox, oy;
	logic signed [16:0] sc;

	always_comb begin
		up_neg = ~in_data.corner[1];
		rt_neg = (in_data.corner[1] == in_data.corner[0]);
		ox = (up_neg ? -18'(cam.up_x) : 18'(cam.up_x))
			+ (rt_neg ? -18'(cam.right_x) : 18'(cam.right_x));
		oy = (up_neg ? -18'(cam.up_y) : 18'(cam.up_y))
			+ (rt_neg ? -18'(cam.right_y) : 18'(cam.right_y));
		sc = $signed({1'b0, cam.scale});
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			r1_s <= in_data;
			px_s1 <= 35'(ox) * 35'(sc);
			py_s1 <= 35'(oy) * 35'(sc);
		end
		if (en2) begin
			r2_s <= r1_s;
			pc_s2 <= 53'(px_s1) * 53'(r1_s.c);
			qs_s2 <= 53'(py_s1) * 53'(r1_s.s);
			ps_s2 <= 53'(px_s1) * 53'(r1_s.s);
			qc_s2 <= 53'(py_s1) * 53'(r1_s.c);
		end
	end

	logic signed [53:0] sx, sy;
	logic signed [33:0] tx, ty;

	always_comb begin
		sx = (54'(pc_s2) - 54'(qs_s2) + 54'sd4194304) >>> 23;
		sy = (54'(ps_s2) + 54'(qc_s2) + 54'sd4194304) >>> 23;
		tx = 34'(r3_s.cx) + 34'(rx_s3);
		ty = 34'(r3_s.cy) + 34'(ry_s3);
	end

	// index entries carry no z or texture corner
	always_comb begin
		r4_n = r3_s;
		if (r3_s.kind == KIND_INDEX) begin
			r4_n.cz = '0;
			r4_n.u = 1'b0;
			r4_n.v = 1'b0;
		end
	end

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -34'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en3) begin
			r3_s <= r2_s;
			rx_s3 <= sx[31:0];
			ry_s3 <= sy[31:0];
		end
		if (en4) begin
			r4_s <= r4_n;
			if (r3_s.kind == KIND_INDEX) begin
				x_s4 <= '0;
				y_s4 <= '0;
				col_s4 <= '0;
			end else begin
				x_s4 <= sat32(tx);
				y_s4 <= sat32(ty);
				col_s4 <= cam.tint;
			end
		end
	end

	assign out_valid = v4_s;
	assign out_rec = r4_s;
	assign out_x = x_s4;
	assign out_y = y_s4;
	assign out_colour = col_s4;

endmodule

### hdl/billboard_quad_expander.sv
// top level of the billboard quad expander
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata: centre, angle, item number
//  m_axis    out  tvalid/tready             tdata: vertex fields, tuser kind, tlast
//  cfg       in   cfg_we (no wait)          cfg_index, cfg_data
//
// the single result port sets the item rate: each item gives four vertex
// records and six index entries, one record per cycle while m_axis_tready is high
// from accept to first record an item passes 18 cordic stages, the sequencer
// register and four corner stages
// reset clears every valid bit and the configuration to its defaults
// a stall on m_axis backs up stage by stage; nothing is dropped or repeated
module billboard_quad_expander #(
	parameter int MAX_ITEMS = 65536,
	parameter int ANGLE_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// centre_x, centre_y, centre_z, item_angle, item_number
	input logic [127:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// vert_x, vert_y, vert_z, tex_u, tex_v, vert_colour, vertex_number, 4 zero bits
	output logic [143:0] m_axis_tdata,
	// record_kind
	output logic m_axis_tuser,
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data
);
	import bqe_pkg::*;

	localparam int AKEEP = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

	// configuration registers
	cam_t cam_q;
	logic [1:0] mode_q;
	logic [15:0] gangle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q.right_x <= 16'sd32767;
			cam_q.right_y <= '0;
			cam_q.up_x <= '0;
			cam_q.up_y <= 16'sd32767;
			cam_q.scale <= 16'd256;
			cam_q.tint <= 24'hffffff;
			mode_q <= MODE_NONE;
			gangle_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RIGHT_X: cam_q.right_x <= cfg_data[15:0];
				REG_RIGHT_Y: cam_q.right_y <= cfg_data[15:0];
				REG_UP_X: cam_q.up_x <= cfg_data[15:0];
				REG_UP_Y: cam_q.up_y <= cfg_data[15:0];
				REG_QUAD_SCALE: cam_q.scale <= cfg_data[15:0];
				REG_TINT_RGB: cam_q.tint <= cfg_data;
				REG_ROT_MODE: mode_q <= cfg_data[1:0];
				REG_GLOBAL_ANGLE: gangle_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// angle pick: unused mode 3 falls back to no rotation
	logic [15:0] ang16;
	logic rot;
	item_t in_item;

	always_comb begin
		ang16 = s_axis_tdata[111:96];
		rot = 1'b0;
		unique case (mode_q)
			MODE_GLOBAL: begin
				ang16 = gangle_q;
				rot = 1'b1;
			end
			MODE_ITEM: rot = 1'b1;
			default: rot = 1'b0;
		endcase
		in_item.cx = s_axis_tdata[31:0];
		in_item.cy = s_axis_tdata[63:32];
		in_item.cz = s_axis_tdata[95:64];
		in_item.item = s_axis_tdata[127:112];
		in_item.quo = '0;
	end

	logic cor_valid, cor_ready;
	rot_t cor_data;

	bqe_cordic #(
		.MAX_ITEMS(MAX_ITEMS),
		.AKEEP(AKEEP)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.angle(ang16[15 -: AKEEP]),
		.rot(rot),
		.in_data(in_item),
		.out_valid(cor_valid),
		.out_ready(cor_ready),
		.out_data(cor_data)
	);

	logic rec_valid, rec_ready;
	rec_t rec_data;

	bqe_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cor_valid),
		.in_ready(cor_ready),
		.in_data(cor_data),
		.out_valid(rec_valid),
		.out_ready(rec_ready),
		.out_data(rec_data)
	);

	rec_t out_rec;
	logic signed [31:0] out_x, out_y;
	logic [23:0] out_colour;

	bqe_corner u_corner (
		.clk(clk),
		.arst_n(arst_n),
		.cam(cam_q),
		.in_valid(rec_valid),
		.in_ready(rec_ready),
		.in_data(rec_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_rec(out_rec),
		.out_x(out_x),
		.out_y(out_y),
		.out_colour(out_colour)
	);

	assign m_axis_tdata = {4'b0000, out_rec.vnum, out_colour, out_rec.v, out_rec.u,
		out_rec.cz, out_y, out_x};
	assign m_axis_tuser = out_rec.kind;
	assign m_axis_tlast = out_rec.last;

	// only the sixth index entry closes an item
	a_last_is_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_INDEX)
		else $error("tlast on a vertex record");

	// texture corner follows the corner number of a vertex record
	a_tex_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_VERTEX |->
		m_axis_tdata[96] == (m_axis_tdata[122] ^ m_axis_tdata[123])
		&& m_axis_tdata[97] == !m_axis_tdata[123])
		else $error("texture corner does not match vertex number");

	// index entries carry no position or colour
	a_index_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_INDEX |-> m_axis_tdata[121:0] == '0)
		else $error("index entry carries vertex payload");

endmodule
